// File: hw/rtl/fcw_pkg.sv
// Package for the flap command watchdog: register map, reset values,
// payload and configuration structs shared by every module of the block.
// No dependencies.
package fcw_pkg;

	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_OPEN_TIMEOUT   = 3'd0,
		REG_STATUS_PERIOD  = 3'd1,
		REG_SWITCH_ID      = 3'd2,
		REG_BRAKE_ID       = 3'd3,
		REG_SERVO_A_CLOSED = 3'd4,
		REG_SERVO_A_OPEN   = 3'd5,
		REG_SERVO_B_CLOSED = 3'd6,
		REG_SERVO_B_OPEN   = 3'd7
	} cfg_reg_t;

	localparam logic [15:0] OPEN_TIMEOUT_RST   = 16'd200;
	localparam logic [15:0] STATUS_PERIOD_RST  = 16'd100;
	localparam logic [10:0] SWITCH_ID_RST      = 11'd1;
	localparam logic [10:0] BRAKE_ID_RST       = 11'd1;
	localparam logic [15:0] SERVO_A_CLOSED_RST = 16'd3300;
	localparam logic [15:0] SERVO_A_OPEN_RST   = 16'd17700;
	localparam logic [15:0] SERVO_B_CLOSED_RST = 16'd17700;
	localparam logic [15:0] SERVO_B_OPEN_RST   = 16'd3300;

	// first status report is due at this tick count
	localparam logic [15:0] STATUS_TICK_RST = 16'd100;

	localparam logic [3:0] SWITCH_FRAME_LEN = 4'd8;
	localparam int OPEN_REQ_BIT = 3;
	localparam int BRAKE_BIT    = 0;

	localparam logic MODE_TICK  = 1'b0;
	localparam logic MODE_FRAME = 1'b1;

	typedef struct packed {
		logic [15:0] open_timeout;
		logic [15:0] status_period;
		logic [10:0] switch_id;
		logic [10:0] brake_id;
		logic [15:0] servo_a_closed;
		logic [15:0] servo_a_open;
		logic [15:0] servo_b_closed;
		logic [15:0] servo_b_open;
	} cfg_t;

	typedef struct packed {
		logic        mode;
		logic [10:0] frame_id;
		logic [3:0]  frame_length;
		logic [7:0]  command_byte;
	} item_t;

	typedef struct packed {
		logic        flap_is_open;
		logic [15:0] servo_a_width;
		logic [15:0] servo_b_width;
		logic        timeout_seen;
		logic        send_status;
	} result_t;

endpackage

// File: hw/rtl/flap_command_watchdog.sv
// Flap command watchdog, top level. An input transfer reaches its result
// transfer through the input register, then the result register.
// Throughput: one item per cycle; the result register is the only stage
// that can hold the input side back, and only while out_stall is high.
// Reset (arst_n low, asynchronous) empties both stages, restores every
// configuration register and the watchdog state to their reset values.
module flap_command_watchdog #(
	parameter int COUNTER_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic [10:0]                         frame_id,
	input  logic [3:0]                          frame_length,
	input  logic [7:0]                          command_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                flap_is_open,
	output logic [15:0]                         servo_a_width,
	output logic [15:0]                         servo_b_width,
	output logic                                timeout_seen,
	output logic                                send_status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fcw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [15:0]                         cfg_data
);

	fcw_pkg::cfg_t    cfg;
	fcw_pkg::item_t   item_s1;
	fcw_pkg::result_t res;
	fcw_pkg::result_t res_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             load_s1;
	logic             load_s2;

	fcw_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (cfg_valid),
		.ready  (cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	fcw_core #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (load_s2),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// advance stage 1 whenever the result register is free or being drained
	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.mode         <= mode;
			item_s1.frame_id     <= frame_id;
			item_s1.frame_length <= frame_length;
			item_s1.command_byte <= command_byte;
		end
		if (load_s2) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign flap_is_open  = res_s2.flap_is_open;
	assign servo_a_width = res_s2.servo_a_width;
	assign servo_b_width = res_s2.servo_b_width;
	assign timeout_seen  = res_s2.timeout_seen;
	assign send_status   = res_s2.send_status;

`ifndef SYNTHESIS
	a_timeout_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && timeout_seen) |=> timeout_seen)
		else $error("timeout flag dropped after being set");

	a_servo_a_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (servo_a_width ==
			(flap_is_open ? cfg.servo_a_open : cfg.servo_a_closed)))
		else $error("servo A width does not follow flap state");

	a_frame_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && (item_s1.mode == fcw_pkg::MODE_FRAME)) |=> !send_status)
		else $error("status raised for a command frame");
`endif

endmodule

// File: hw/rtl/fcw_cfg_regs.sv
// Configuration register file of the flap command watchdog.
// Depends on fcw_pkg for the register map and reset values.
module fcw_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid,
	output logic                                ready,
	input  logic [fcw_pkg::CFG_INDEX_BITS-1:0]  index,
	input  logic [15:0]                         data,
	output fcw_pkg::cfg_t                       cfg
);

	fcw_pkg::cfg_t cfg_q;

	assign ready = 1'b1;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_timeout   <= fcw_pkg::OPEN_TIMEOUT_RST;
			cfg_q.status_period  <= fcw_pkg::STATUS_PERIOD_RST;
			cfg_q.switch_id      <= fcw_pkg::SWITCH_ID_RST;
			cfg_q.brake_id       <= fcw_pkg::BRAKE_ID_RST;
			cfg_q.servo_a_closed <= fcw_pkg::SERVO_A_CLOSED_RST;
			cfg_q.servo_a_open   <= fcw_pkg::SERVO_A_OPEN_RST;
			cfg_q.servo_b_closed <= fcw_pkg::SERVO_B_CLOSED_RST;
			cfg_q.servo_b_open   <= fcw_pkg::SERVO_B_OPEN_RST;
		end else if (valid && ready) begin
			case (fcw_pkg::cfg_reg_t'(index))
				fcw_pkg::REG_OPEN_TIMEOUT:   cfg_q.open_timeout   <= data;
				fcw_pkg::REG_STATUS_PERIOD:  cfg_q.status_period  <= data;
				fcw_pkg::REG_SWITCH_ID:      cfg_q.switch_id      <= data[10:0];
				fcw_pkg::REG_BRAKE_ID:       cfg_q.brake_id       <= data[10:0];
				fcw_pkg::REG_SERVO_A_CLOSED: cfg_q.servo_a_closed <= data;
				fcw_pkg::REG_SERVO_A_OPEN:   cfg_q.servo_a_open   <= data;
				fcw_pkg::REG_SERVO_B_CLOSED: cfg_q.servo_b_closed <= data;
				fcw_pkg::REG_SERVO_B_OPEN:   cfg_q.servo_b_open   <= data;
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/fcw_core.sv
// Watchdog state and its single-pass update for one tick or command frame.
// Depends on fcw_pkg for the item, result and configuration structs.
module fcw_core #(
	parameter int COUNTER_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  fcw_pkg::item_t    item,
	input  fcw_pkg::cfg_t     cfg,
	output fcw_pkg::result_t  res
);

	logic [COUNTER_BITS-1:0] tick_count_q;
	logic [COUNTER_BITS-1:0] command_stamp_q;
	logic [COUNTER_BITS-1:0] next_status_q;
	logic                    flap_open_q;
	logic                    open_allowed_q;
	logic                    timeout_flag_q;

	logic [COUNTER_BITS-1:0] tick_inc;
	logic [COUNTER_BITS-1:0] stale_limit;
	logic                    status_hit;
	logic                    is_switch;
	logic                    is_brake;

	logic [COUNTER_BITS-1:0] tick_count_d;
	logic [COUNTER_BITS-1:0] command_stamp_d;
	logic [COUNTER_BITS-1:0] next_status_d;
	logic                    flap_open_d;
	logic                    open_allowed_d;
	logic                    timeout_flag_d;
	logic                    send_status_d;

	assign tick_inc    = tick_count_q + COUNTER_BITS'(1);
	assign stale_limit = tick_inc - COUNTER_BITS'(cfg.open_timeout);
	assign status_hit  = (tick_inc == next_status_q);
	assign is_switch   = (item.frame_id == cfg.switch_id) &&
		(item.frame_length == fcw_pkg::SWITCH_FRAME_LEN);
	assign is_brake    = (item.frame_id == cfg.brake_id);

	always_comb begin
		tick_count_d    = tick_count_q;
		command_stamp_d = command_stamp_q;
		next_status_d   = next_status_q;
		flap_open_d     = flap_open_q;
		open_allowed_d  = open_allowed_q;
		timeout_flag_d  = timeout_flag_q;
		send_status_d   = 1'b0;
		if (item.mode == fcw_pkg::MODE_TICK) begin
			tick_count_d = tick_inc;
			if (status_hit) begin
				next_status_d = next_status_q + COUNTER_BITS'(cfg.status_period);
				send_status_d = 1'b1;
			end
			// no command stamped recently: force closed
			if (stale_limit > command_stamp_q) begin
				timeout_flag_d = 1'b1;
				flap_open_d    = 1'b0;
			end
		end else begin
			if (is_switch) begin
				if (item.command_byte[fcw_pkg::OPEN_REQ_BIT]) begin
					if (open_allowed_q) begin
						flap_open_d     = 1'b1;
						command_stamp_d = tick_count_q;
					end
				end else begin
					flap_open_d     = 1'b0;
					command_stamp_d = tick_count_q;
				end
			end
			// brake handled after the switch so it wins on a shared id
			if (is_brake) begin
				if (item.command_byte[fcw_pkg::BRAKE_BIT]) begin
					open_allowed_d = 1'b0;
					flap_open_d    = 1'b0;
				end else begin
					open_allowed_d = 1'b1;
				end
			end
		end
	end

	always_comb begin
		res.flap_is_open  = flap_open_d;
		res.servo_a_width = flap_open_d ? cfg.servo_a_open : cfg.servo_a_closed;
		res.servo_b_width = flap_open_d ? cfg.servo_b_open : cfg.servo_b_closed;
		res.timeout_seen  = timeout_flag_d;
		res.send_status   = send_status_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q    <= '0;
			command_stamp_q <= '0;
			next_status_q   <= COUNTER_BITS'(fcw_pkg::STATUS_TICK_RST);
			flap_open_q     <= 1'b0;
			open_allowed_q  <= 1'b1;
			timeout_flag_q  <= 1'b0;
		end else if (advance) begin
			tick_count_q    <= tick_count_d;
			command_stamp_q <= command_stamp_d;
			next_status_q   <= next_status_d;
			flap_open_q     <= flap_open_d;
			open_allowed_q  <= open_allowed_d;
			timeout_flag_q  <= timeout_flag_d;
		end
	end

endmodule

// File: tb/sv/tb_flap_command_watchdog.sv
// Testbench for flap_command_watchdog: directed frame and tick cases, then
// random phases under several register settings and idling patterns.
// Depends on fcw_pkg and the flap_command_watchdog RTL only.
`timescale 1ns / 1ps

module tb_flap_command_watchdog;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_ITEMS  = 200;
	localparam int PHASE_COUNT  = 8;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [10:0] frame_id;
	logic [3:0]  frame_length;
	logic [7:0]  command_byte;
	logic        out_valid;
	logic        out_stall;
	logic        flap_is_open;
	logic [15:0] servo_a_width;
	logic [15:0] servo_b_width;
	logic        timeout_seen;
	logic        send_status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [fcw_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [15:0] cfg_data;

	flap_command_watchdog dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.frame_id     (frame_id),
		.frame_length (frame_length),
		.command_byte (command_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.flap_is_open (flap_is_open),
		.servo_a_width(servo_a_width),
		.servo_b_width(servo_b_width),
		.timeout_seen (timeout_seen),
		.send_status  (send_status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// watchdog state and register copy
	fcw_pkg::cfg_t regs;
	logic [31:0]   ticks;
	logic [31:0]   stamp;
	logic [31:0]   next_status;
	logic          flap_open;
	logic          open_allowed;
	logic          timed_out;

	fcw_pkg::result_t flap_results_q[$];
	int               fail_count;
	int               cycle_count;
	int               send_idle_pct;
	int               rx_stall_pct;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk)
		if (arst_n)
			out_stall <= ($urandom_range(99) < rx_stall_pct);

	task automatic reset_watchdog();
		regs.open_timeout   = fcw_pkg::OPEN_TIMEOUT_RST;
		regs.status_period  = fcw_pkg::STATUS_PERIOD_RST;
		regs.switch_id      = fcw_pkg::SWITCH_ID_RST;
		regs.brake_id       = fcw_pkg::BRAKE_ID_RST;
		regs.servo_a_closed = fcw_pkg::SERVO_A_CLOSED_RST;
		regs.servo_a_open   = fcw_pkg::SERVO_A_OPEN_RST;
		regs.servo_b_closed = fcw_pkg::SERVO_B_CLOSED_RST;
		regs.servo_b_open   = fcw_pkg::SERVO_B_OPEN_RST;
		ticks        = '0;
		stamp        = '0;
		next_status  = 32'(fcw_pkg::STATUS_TICK_RST);
		flap_open    = 1'b0;
		open_allowed = 1'b1;
		timed_out    = 1'b0;
	endtask

	function automatic fcw_pkg::result_t advance_watchdog(fcw_pkg::item_t it);
		fcw_pkg::result_t r;
		logic             status_due;
		status_due = 1'b0;
		if (it.mode == fcw_pkg::MODE_TICK) begin
			ticks = ticks + 32'd1;
			if (ticks == next_status) begin
				next_status = next_status + 32'(regs.status_period);
				status_due = 1'b1;
			end
			if ((ticks - 32'(regs.open_timeout)) > stamp) begin
				timed_out = 1'b1;
				flap_open = 1'b0;
			end
		end else begin
			if (it.frame_id == regs.switch_id &&
				it.frame_length == fcw_pkg::SWITCH_FRAME_LEN) begin
				if (it.command_byte[fcw_pkg::OPEN_REQ_BIT]) begin
					if (open_allowed) begin
						flap_open = 1'b1;
						stamp = ticks;
					end
				end else begin
					flap_open = 1'b0;
					stamp = ticks;
				end
			end
			// brake is handled after the switch, so it wins on a shared id
			if (it.frame_id == regs.brake_id) begin
				if (it.command_byte[fcw_pkg::BRAKE_BIT]) begin
					open_allowed = 1'b0;
					flap_open = 1'b0;
				end else begin
					open_allowed = 1'b1;
				end
			end
		end
		r.flap_is_open  = flap_open;
		r.servo_a_width = flap_open ? regs.servo_a_open : regs.servo_a_closed;
		r.servo_b_width = flap_open ? regs.servo_b_open : regs.servo_b_closed;
		r.timeout_seen  = timed_out;
		r.send_status   = status_due;
		return r;
	endfunction

	always @(posedge clk) begin
		fcw_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (flap_results_q.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				want = flap_results_q.pop_front();
				if (flap_is_open !== want.flap_is_open) begin
					$error("flap_is_open: expected %0d, got %0d", want.flap_is_open, flap_is_open);
					fail_count++;
				end
				if (servo_a_width !== want.servo_a_width) begin
					$error("servo_a_width: expected %0d, got %0d",
						want.servo_a_width, servo_a_width);
					fail_count++;
				end
				if (servo_b_width !== want.servo_b_width) begin
					$error("servo_b_width: expected %0d, got %0d",
						want.servo_b_width, servo_b_width);
					fail_count++;
				end
				if (timeout_seen !== want.timeout_seen) begin
					$error("timeout_seen: expected %0d, got %0d", want.timeout_seen, timeout_seen);
					fail_count++;
				end
				if (send_status !== want.send_status) begin
					$error("send_status: expected %0d, got %0d", want.send_status, send_status);
					fail_count++;
				end
			end
		end
	end

	task automatic send_item(fcw_pkg::item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 20)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= it.mode;
		frame_id     <= it.frame_id;
		frame_length <= it.frame_length;
		command_byte <= it.command_byte;
		do @(posedge clk); while (in_stall);
		flap_results_q.push_back(advance_watchdog(it));
	endtask

	task automatic send_tick();
		fcw_pkg::item_t it;
		it = '0;
		it.mode = fcw_pkg::MODE_TICK;
		it.frame_id = 11'($urandom);
		it.frame_length = 4'($urandom);
		it.command_byte = 8'($urandom);
		send_item(it);
	endtask

	task automatic send_frame(logic [10:0] id, logic [3:0] len, logic [7:0] cmd);
		fcw_pkg::item_t it;
		it.mode = fcw_pkg::MODE_FRAME;
		it.frame_id = id;
		it.frame_length = len;
		it.command_byte = cmd;
		send_item(it);
	endtask

	// hold the sender until every result is back, then let the pipeline settle
	task automatic drain();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (flap_results_q.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (flap_results_q.size() != 0) begin
			$error("%0d results never arrived", flap_results_q.size());
			fail_count++;
			flap_results_q.delete();
		end
	endtask

	task automatic write_reg(fcw_pkg::cfg_reg_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			fcw_pkg::REG_OPEN_TIMEOUT:   regs.open_timeout   = value;
			fcw_pkg::REG_STATUS_PERIOD:  regs.status_period  = value;
			fcw_pkg::REG_SWITCH_ID:      regs.switch_id      = value[10:0];
			fcw_pkg::REG_BRAKE_ID:       regs.brake_id       = value[10:0];
			fcw_pkg::REG_SERVO_A_CLOSED: regs.servo_a_closed = value;
			fcw_pkg::REG_SERVO_A_OPEN:   regs.servo_a_open   = value;
			fcw_pkg::REG_SERVO_B_CLOSED: regs.servo_b_closed = value;
			fcw_pkg::REG_SERVO_B_OPEN:   regs.servo_b_open   = value;
			default: ;
		endcase
	endtask

	task automatic apply_settings(fcw_pkg::cfg_t s);
		write_reg(fcw_pkg::REG_OPEN_TIMEOUT,   s.open_timeout);
		write_reg(fcw_pkg::REG_STATUS_PERIOD,  s.status_period);
		write_reg(fcw_pkg::REG_SWITCH_ID,      16'(s.switch_id));
		write_reg(fcw_pkg::REG_BRAKE_ID,       16'(s.brake_id));
		write_reg(fcw_pkg::REG_SERVO_A_CLOSED, s.servo_a_closed);
		write_reg(fcw_pkg::REG_SERVO_A_OPEN,   s.servo_a_open);
		write_reg(fcw_pkg::REG_SERVO_B_CLOSED, s.servo_b_closed);
		write_reg(fcw_pkg::REG_SERVO_B_OPEN,   s.servo_b_open);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_frame_handling();
		fcw_pkg::cfg_t s;
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		// first tick after reset trips the watchdog
		send_tick();
		send_frame(11'd1, 4'd8, 8'h08);
		send_frame(11'd1, 4'd9, 8'h08);
		send_frame(11'd1, 4'd15, 8'h08);
		send_frame(11'd1, 4'd8, 8'h00);
		send_frame(11'd1, 4'd8, 8'h08);
		// shared id: brake beats the open request
		send_frame(11'd1, 4'd8, 8'h09);
		send_frame(11'd1, 4'd8, 8'h08);
		drain();
		s = regs;
		s.switch_id = 11'd5;
		s.brake_id  = 11'd6;
		apply_settings(s);
		send_frame(11'd6, 4'd0, 8'h01);
		send_frame(11'd5, 4'd8, 8'hFF);
		send_frame(11'd5, 4'd8, 8'h00);
		send_frame(11'd6, 4'd15, 8'hFE);
		send_frame(11'd5, 4'd8, 8'hFF);
		send_frame(11'd5, 4'd7, 8'hF7);
		send_frame(11'd2047, 4'd15, 8'hFF);
		send_frame(11'd0, 4'd0, 8'h00);
		send_tick();
		send_tick();
		send_frame(11'd5, 4'd8, 8'hF7);
		send_tick();
		drain();
	endtask

	function automatic fcw_pkg::cfg_t phase_settings(int phase);
		fcw_pkg::cfg_t s;
		s.open_timeout   = 16'($urandom_range(1, 40));
		s.status_period  = 16'($urandom_range(1, 20));
		s.switch_id      = 11'($urandom);
		s.brake_id       = ($urandom_range(3) == 0) ? s.switch_id : 11'($urandom);
		s.servo_a_closed = 16'($urandom);
		s.servo_a_open   = 16'($urandom);
		s.servo_b_closed = 16'($urandom);
		s.servo_b_open   = 16'($urandom);
		case (phase)
			0: begin
				s.open_timeout = 16'd1;
				s.status_period = 16'd1;
				s.switch_id = 11'd0;
				s.brake_id = 11'd2047;
				s.servo_a_closed = 16'd0;
				s.servo_a_open = 16'hFFFF;
				s.servo_b_closed = 16'hFFFF;
				s.servo_b_open = 16'd0;
			end
			1: begin
				s.open_timeout = 16'hFFFF;
				s.switch_id = 11'd2047;
				s.brake_id = 11'd0;
				s.servo_a_closed = 16'hFFFF;
				s.servo_a_open = 16'd0;
				s.servo_b_closed = 16'd0;
				s.servo_b_open = 16'hFFFF;
			end
			PHASE_COUNT - 1: begin
				s.open_timeout = 16'd2;
				s.status_period = 16'hFFFF;
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic send_random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55)
			send_tick();
		else if (pick < 75)
			send_frame(regs.switch_id, fcw_pkg::SWITCH_FRAME_LEN, 8'($urandom));
		else if (pick < 85)
			send_frame(regs.brake_id, 4'($urandom),
				8'($urandom) & 8'hFE | 8'($urandom_range(3) == 0));
		else if (pick < 91)
			send_frame(regs.switch_id, 4'($urandom), 8'($urandom));
		else
			send_frame(11'($urandom), 4'($urandom), 8'($urandom));
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			drain();
			apply_settings(phase_settings(phase));
			case (phase % 4)
				0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin send_idle_pct = 48; rx_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rx_stall_pct = 48; end
				default: begin send_idle_pct = 8; rx_stall_pct = 8; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random_item();
		end
		drain();
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = fcw_pkg::MODE_TICK;
		frame_id     = '0;
		frame_length = '0;
		command_byte = '0;
		out_stall    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = fcw_pkg::REG_OPEN_TIMEOUT;
		cfg_data     = '0;
		fail_count   = 0;
		cycle_count  = 0;
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		reset_watchdog();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_frame_handling();
		test_random_phases();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: flap_command_watchdog.f
hw/rtl/fcw_pkg.sv
hw/rtl/fcw_cfg_regs.sv
hw/rtl/fcw_core.sv
hw/rtl/flap_command_watchdog.sv
tb/sv/tb_flap_command_watchdog.sv
